// ===== hdl/ps2ma_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2ma_pkg
// Types and constants shared by the PS/2 mouse packet accumulator.
// ----------------------------------------------------------------------------
package ps2ma_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_WHEEL_MODE = 1'b0;

    // request codes
    localparam logic FUNC_RX_BYTE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    localparam logic [7:0] ACK_BYTE  = 8'hFA;
    localparam int         SYNC_BIT  = 3;
    localparam int         XSIGN_BIT = 4;
    localparam int         YSIGN_BIT = 5;
    localparam int         XOVF_BIT  = 6;
    localparam int         YOVF_BIT  = 7;

    localparam logic signed [7:0] WHEEL_MAX = 8'sd7;
    localparam logic signed [7:0] WHEEL_MIN = -8'sd8;

    typedef struct packed {
        logic       valid;
        logic       func;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [2:0]        buttons;
        logic signed [8:0] dx;
        logic signed [8:0] dy;
        logic signed [7:0] wheel;
    } pkt_t;

    function automatic logic signed [7:0] clamp_wheel(input logic [7:0] raw);
        logic signed [7:0] w;
        w = $signed(raw);
        if (w > WHEEL_MAX)
            return WHEEL_MAX;
        else if (w < WHEEL_MIN)
            return WHEEL_MIN;
        else
            return w;
    endfunction

endpackage

// ===== hdl/ps2ma_if.sv =====
// ----------------------------------------------------------------------------
// ps2ma_req_if / ps2ma_rsp_if
// Valid/ready channels for requests and read results.
// ----------------------------------------------------------------------------
interface ps2ma_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface ps2ma_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic signed [7:0]  wheel_sum;
    logic [2:0]         button_bits;
    logic               has_motion;

    modport source (output valid, output move_x, output move_y, output wheel_sum,
                    output button_bits, output has_motion, input ready);
    modport sink   (input valid, input move_x, input move_y, input wheel_sum,
                    input button_bits, input has_motion, output ready);
endinterface

// ===== hdl/ps2_mouse_packet_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_accumulator_core
// Gathers PS/2 mouse bytes into packets, accumulates motion and answers reads.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  --------+-----------+------------------------------------------------------
//  req     | in        | func, rx_byte (mouse byte or read-and-clear request)
//  rsp     | out       | move_x, move_y, wheel_sum, button_bits, has_motion
//  apb     | in        | wheel_mode register at byte address 0
//
//  one request beat per cycle while no read is held; a beat is registered in
//  the input register and then applied to the framer and accumulators, where a
//  read also loads the result register and sets rsp.valid
//  mouse bytes never stall in the input register; a read waits there only while an
//  earlier result is still held and rsp.ready is low
//  rst_n clears byte position, sums, buttons and both valid flags at once
// ----------------------------------------------------------------------------
module ps2_mouse_packet_accumulator_core #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ps2ma_req_if.sink                     req,
    ps2ma_rsp_if.source                   rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ps2ma_pkg::PADDR_W-1:0] paddr,
    input  logic [ps2ma_pkg::PDATA_W-1:0] pwdata,
    output logic [ps2ma_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import ps2ma_pkg::*;

    item_t item;
    pkt_t  pkt;
    logic  advance;
    logic  wheel_mode_reg;
    logic  wheel_mode_next;
    logic  reg_hit;

    // register file: single mode bit, index from paddr[2]
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_WHEEL_MODE);

    always_comb
    begin
        wheel_mode_next = wheel_mode_reg;
        if (psel && penable && pwrite && reg_hit)
            wheel_mode_next = pwdata[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_mode_reg <= 1'b0;
        else
            wheel_mode_reg <= wheel_mode_next;
    end

    assign prdata = reg_hit ? PDATA_W'(wheel_mode_reg) : '0;

    // input register stage
    ps2ma_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (advance),
        .item    (item)
    );

    // packet assembly and decode
    ps2ma_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .wheel_mode (wheel_mode_reg),
        .pkt        (pkt)
    );

    // accumulators and result register; also decides when the stage moves
    ps2ma_accum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .pkt     (pkt),
        .advance (advance),
        .rsp     (rsp)
    );

endmodule

// ===== hdl/ps2ma_in_reg.sv =====
// ----------------------------------------------------------------------------
// ps2ma_in_reg
// Input register stage for request beats.
// ----------------------------------------------------------------------------
module ps2ma_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    ps2ma_req_if.sink       req,
    input  logic            advance,
    output ps2ma_pkg::item_t item
);
    import ps2ma_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       func_reg;
    logic [7:0] byte_reg;
    logic       take;

    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg <= req.func;
            byte_reg <= req.rx_byte;
        end
    end

    assign item.valid   = valid_reg;
    assign item.func    = func_reg;
    assign item.rx_byte = byte_reg;

endmodule

// ===== hdl/ps2ma_framer.sv =====
// ----------------------------------------------------------------------------
// ps2ma_framer
// Gathers mouse bytes into packets and decodes a completed packet.
// ----------------------------------------------------------------------------
module ps2ma_framer (
    input  logic             clk,
    input  logic             rst_n,
    input  ps2ma_pkg::item_t item,
    input  logic             advance,
    input  logic             wheel_mode,
    output ps2ma_pkg::pkt_t  pkt
);
    import ps2ma_pkg::*;

    logic [1:0] pos_reg;
    logic [1:0] pos_next;
    logic [7:0] pb_reg [3];
    logic [7:0] b;
    logic       byte_beat;
    logic       drop;
    logic       complete;
    logic       store;
    logic [1:0] last_pos;
    logic [7:0] status;

    assign b         = item.rx_byte;
    assign byte_beat = advance && (item.func == FUNC_RX_BYTE);
    assign drop      = (b == ACK_BYTE) || ((pos_reg == 2'd0) && !b[SYNC_BIT]);
    assign last_pos  = wheel_mode ? 2'd3 : 2'd2;
    assign complete  = pos_reg >= last_pos;
    assign store     = byte_beat && !drop && (pos_reg != 2'd3);

    always_comb
    begin
        pos_next = pos_reg;
        if (byte_beat && !drop)
        begin
            if (complete)
                pos_next = 2'd0;
            else
                pos_next = pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= 2'd0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (store)
            pb_reg[pos_reg] <= b;
    end

    // decode; the last byte is taken straight from the beat
    assign status = pb_reg[0];

    always_comb
    begin
        pkt.valid   = byte_beat && !drop && complete && status[SYNC_BIT]
                      && !status[XOVF_BIT] && !status[YOVF_BIT];
        pkt.buttons = status[2:0];
        pkt.dx      = $signed({status[XSIGN_BIT], pb_reg[1]});
        pkt.dy      = (pos_reg == 2'd2) ? $signed({status[YSIGN_BIT], b})
                                        : $signed({status[YSIGN_BIT], pb_reg[2]});
        pkt.wheel   = wheel_mode ? clamp_wheel(b) : 8'sd0;
    end

endmodule

// ===== hdl/ps2ma_accum.sv =====
// ----------------------------------------------------------------------------
// ps2ma_accum
// Motion accumulators, button latch and read result register.
// ----------------------------------------------------------------------------
module ps2ma_accum #(
    parameter int ACC_WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ps2ma_pkg::item_t item,
    input  ps2ma_pkg::pkt_t  pkt,
    output logic             advance,
    ps2ma_rsp_if.source      rsp
);
    import ps2ma_pkg::*;

    logic signed [ACC_WIDTH-1:0] sum_x_reg, sum_x_next;
    logic signed [ACC_WIDTH-1:0] sum_y_reg, sum_y_next;
    logic signed [7:0]           sum_w_reg, sum_w_next;
    logic [2:0]                  btn_reg, btn_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        read_beat;

    assign advance   = item.valid && ((item.func == FUNC_RX_BYTE) || !out_valid_reg
                                      || rsp.ready);
    assign read_beat = advance && (item.func == FUNC_READ);

    always_comb
    begin
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        sum_w_next     = sum_w_reg;
        btn_next       = btn_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        if (read_beat)
        begin
            sum_x_next     = '0;
            sum_y_next     = '0;
            sum_w_next     = '0;
            out_valid_next = 1'b1;
        end
        else if (pkt.valid)
        begin
            sum_x_next = sum_x_reg + ACC_WIDTH'(pkt.dx);
            sum_y_next = sum_y_reg + ACC_WIDTH'(pkt.dy);
            sum_w_next = sum_w_reg + pkt.wheel;
            btn_next   = pkt.buttons;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_w_reg     <= '0;
            btn_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            sum_w_reg     <= sum_w_next;
            btn_reg       <= btn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register, loaded by a read beat
    always_ff @(posedge clk)
    begin
        if (read_beat)
        begin
            rsp.move_x      <= 16'(sum_x_reg);
            rsp.move_y      <= 16'(sum_y_reg);
            rsp.wheel_sum   <= sum_w_reg;
            rsp.button_bits <= btn_reg;
            rsp.has_motion  <= (sum_x_reg != '0) || (sum_y_reg != '0) || (sum_w_reg != '0);
        end
    end

    assign rsp.valid = out_valid_reg;

endmodule

// ===== bench/ps2ma_motion_checker.sv =====
// ----------------------------------------------------------------------------
// ps2ma_motion_checker
// Watches the request, result and register ports of the PS/2 mouse packet
// accumulator. It keeps its own framer and motion sums, predicts every read
// report, and compares each result beat with the oldest report still owed.
// ----------------------------------------------------------------------------
module ps2ma_motion_checker #(
    parameter int ACC_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ps2ma_req_if                          req,
    ps2ma_rsp_if                          rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ps2ma_pkg::PADDR_W-1:0] paddr,
    input  logic [ps2ma_pkg::PDATA_W-1:0] pwdata,
    output int                            mismatches,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ps2ma_pkg::*;

    localparam logic [7:0] WHEEL_FLOOR = 8'hF8;
    localparam logic [7:0] WHEEL_CEIL  = 8'h07;

    typedef struct {
        logic [15:0] move_x;
        logic [15:0] move_y;
        logic [7:0]  wheel_sum;
        logic [2:0]  button_bits;
        logic        has_motion;
    } motion_report_t;

    motion_report_t owed_reports[$];

    logic                 wheel_on;
    logic [1:0]           frame_pos;
    logic [7:0]           frame_bytes[3];
    logic [ACC_WIDTH-1:0] acc_x;
    logic [ACC_WIDTH-1:0] acc_y;
    logic [7:0]           acc_wheel;
    logic [2:0]           latched_buttons;

    // sign-extend the accumulator, keep the low 16 bits
    function automatic logic [15:0] to_report16(input logic [ACC_WIDTH-1:0] acc);
        logic signed [63:0] wide;
        wide = $signed(acc);
        return wide[15:0];
    endfunction

    function automatic logic [ACC_WIDTH-1:0] widen_delta(input logic [7:0] low,
                                                         input logic neg);
        return {{(ACC_WIDTH-8){neg}}, low};
    endfunction

    function automatic logic [7:0] clip_wheel(input logic [7:0] raw);
        if (raw[7] && raw < WHEEL_FLOOR)
            return WHEEL_FLOOR;
        if (!raw[7] && raw > WHEEL_CEIL)
            return WHEEL_CEIL;
        return raw;
    endfunction

    function automatic void close_packet(input logic [7:0] last);
        logic [7:0] status;
        logic [7:0] step;
        status = frame_bytes[0];
        if (!status[SYNC_BIT] || status[XOVF_BIT] || status[YOVF_BIT])
            return;
        step            = wheel_on ? clip_wheel(last) : 8'h00;
        acc_x           = acc_x + widen_delta(frame_bytes[1], status[XSIGN_BIT]);
        acc_y           = acc_y + widen_delta(frame_bytes[2], status[YSIGN_BIT]);
        acc_wheel       = acc_wheel + step;
        latched_buttons = status[2:0];
    endfunction

    function automatic void take_mouse_byte(input logic [7:0] b);
        int fill;
        if (b == ACK_BYTE)
            return;
        if (frame_pos == 2'd0 && !b[SYNC_BIT])
            return;
        fill = int'(frame_pos) + 1;
        if (fill >= (wheel_on ? 4 : 3))
        begin
            if (frame_pos < 2'd3)
                frame_bytes[frame_pos] = b;
            close_packet(b);
            frame_pos = 2'd0;
        end
        else
        begin
            frame_bytes[frame_pos] = b;
            frame_pos              = frame_pos + 2'd1;
        end
    endfunction

    function automatic void take_read_request();
        motion_report_t rpt;
        rpt.move_x      = to_report16(acc_x);
        rpt.move_y      = to_report16(acc_y);
        rpt.wheel_sum   = acc_wheel;
        rpt.button_bits = latched_buttons;
        rpt.has_motion  = (acc_x != '0) || (acc_y != '0) || (acc_wheel != 8'h00);
        owed_reports.push_back(rpt);
        acc_x     = '0;
        acc_y     = '0;
        acc_wheel = 8'h00;
    endfunction

    function automatic void compare_report();
        motion_report_t want;
        if (owed_reports.size() == 0)
        begin
            $error("result beat with no read waiting");
            mismatches++;
            return;
        end
        want = owed_reports.pop_front();
        if (rsp.move_x !== want.move_x)
        begin
            $error("move_x: expected %0d, got %0d", $signed(want.move_x), rsp.move_x);
            mismatches++;
        end
        if (rsp.move_y !== want.move_y)
        begin
            $error("move_y: expected %0d, got %0d", $signed(want.move_y), rsp.move_y);
            mismatches++;
        end
        if (rsp.wheel_sum !== want.wheel_sum)
        begin
            $error("wheel_sum: expected %0d, got %0d", $signed(want.wheel_sum),
                   rsp.wheel_sum);
            mismatches++;
        end
        if (rsp.button_bits !== want.button_bits)
        begin
            $error("button_bits: expected %0d, got %0d", want.button_bits,
                   rsp.button_bits);
            mismatches++;
        end
        if (rsp.has_motion !== want.has_motion)
        begin
            $error("has_motion: expected %0d, got %0d", want.has_motion, rsp.has_motion);
            mismatches++;
        end
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_on        = 1'b0;
            frame_pos       = 2'd0;
            acc_x           = '0;
            acc_y           = '0;
            acc_wheel       = 8'h00;
            latched_buttons = 3'd0;
            owed_reports.delete();
            outstanding     = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                compare_report();
            if (req.valid && req.ready)
            begin
                if (req.func == FUNC_READ)
                    take_read_request();
                else
                    take_mouse_byte(req.rx_byte);
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_WHEEL_MODE)
                wheel_on = pwdata[0];
            outstanding = owed_reports.size();
        end
    end

endmodule

// ===== bench/tb_ps2_mouse_packet_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_accumulator_core
// Drives mouse bytes, read requests and wheel-mode writes into the PS/2 mouse
// packet accumulator, with random stalls on both channels, and reports the
// verdict of the checker that sits beside the block.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_packet_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2ma_pkg::*;

    localparam int ACC_W       = 16;
    localparam int STALL_LIMIT = 2000;   // cycles with no beat at all
    localparam int PHASES      = 7;

    // per random phase: packet size, steady drift, rough count of beats
    localparam bit PHASE_WIDE [PHASES]   = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam bit PHASE_DRIFT [PHASES]  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam int PHASE_BUDGET [PHASES] = '{220, 220, 460, 220, 240, 200, 150};

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               calm  = 1'b0;   // no idling on either side once set
    int                 mismatches;
    int                 outstanding;
    int                 quiet_cycles = 0;

    ps2ma_req_if req_ch ();
    ps2ma_rsp_if rsp_ch ();

    ps2_mouse_packet_accumulator_core #(
        .ACC_WIDTH (ACC_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ps2ma_motion_checker #(
        .ACC_WIDTH (ACC_W)
    ) motion_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: ready drops for random bursts, changing
    // only at the falling edge so the block sees a settled value
    initial
    begin
        int hold;
        hold         = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    hold = $urandom_range(1, 18);
            end
        end
    end

    // watchdog: any accepted beat on any port restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (psel && penable && pready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[ps2_mouse_packet_accumulator_core] ERROR");
                $finish;
            end
        end
    end

    // one request beat; entered and left at a falling edge, with valid kept
    // high so back-to-back beats need no second assignment in the same step
    task automatic send_beat(input logic f, input logic [7:0] b);
        req_ch.valid   <= 1'b1;
        req_ch.func    <= f;
        req_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        // sender gap
        if (!calm && $urandom_range(0, 15) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
    endtask

    // one movement packet, with an occasional acknowledge byte slipped in
    // between the first three bytes when sprinkle is set
    task automatic send_frame(input logic [7:0] status, input logic [7:0] dx,
                              input logic [7:0] dy, input logic [7:0] wh,
                              input logic wide, input logic sprinkle);
        send_beat(FUNC_RX_BYTE, status);
        if (sprinkle && $urandom_range(0, 19) == 0)
            send_beat(FUNC_RX_BYTE, ACK_BYTE);
        send_beat(FUNC_RX_BYTE, dx);
        if (sprinkle && $urandom_range(0, 19) == 0)
            send_beat(FUNC_RX_BYTE, ACK_BYTE);
        send_beat(FUNC_RX_BYTE, dy);
        if (wide)
            send_beat(FUNC_RX_BYTE, wh);
    endtask

    // register writes only with the block idle: every report in, then a wait
    // so the last mouse byte has passed through the framer
    task automatic set_wheel_mode(input logic wide);
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (5) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_WHEEL_MODE, 2'b00};
        pwdata  <= {{(PDATA_W-1){1'b0}}, wide};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // byte with the edge values turning up often
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic       drift;
        logic       wide;
        logic       xs;
        logic       ys;
        logic       ws;
        logic [7:0] status;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] wh;
        int         budget;
        int         pick;

        // every input known from time zero
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_RX_BYTE;
        req_ch.rx_byte = 8'h00;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed part, three-byte packets ----------------
        send_beat(FUNC_READ, 8'hFF);                 // nothing gathered yet
        send_beat(FUNC_RX_BYTE, ACK_BYTE);           // acknowledge at frame start
        send_beat(FUNC_RX_BYTE, 8'h00);              // no sync bit, dropped
        send_frame(8'hC8, 8'h10, 8'h10, 8'h00, 1'b0, 1'b0);  // overflow, thrown away
        send_beat(FUNC_READ, 8'h00);                 // zero sums, no motion
        send_beat(FUNC_RX_BYTE, 8'h0F);              // all buttons, positive
        send_beat(FUNC_RX_BYTE, ACK_BYTE);           // acknowledge mid-packet
        send_beat(FUNC_RX_BYTE, 8'hFF);
        send_beat(FUNC_RX_BYTE, 8'h00);
        send_frame(8'h3C, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0);  // most negative deltas
        send_beat(FUNC_READ, 8'h5A);

        // ---------------- directed part, wheel packets ----------------
        set_wheel_mode(1'b1);
        send_frame(8'h09, 8'h01, 8'hFF, 8'h80, 1'b1, 1'b0);  // wheel pinned at floor
        send_beat(FUNC_RX_BYTE, 8'h0A);
        send_beat(FUNC_RX_BYTE, 8'h05);
        send_beat(FUNC_READ, 8'h00);                 // read with a packet half done
        send_beat(FUNC_RX_BYTE, 8'h05);
        // three bytes held; dropping back to short packets lets the next
        // byte close the packet with no wheel step
        set_wheel_mode(1'b0);
        send_beat(FUNC_RX_BYTE, 8'h33);
        send_beat(FUNC_READ, 8'h00);

        // ---------------- random phases ----------------
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wide  = PHASE_WIDE[ph];
            drift = PHASE_DRIFT[ph];
            set_wheel_mode(wide);
            calm   = (ph == PHASES - 1);
            xs     = 1'($urandom);
            ys     = 1'($urandom);
            ws     = 1'($urandom);
            budget = PHASE_BUDGET[ph];
            while (budget > 0)
            begin
                pick = $urandom_range(0, 15);
                if (!drift && pick < 4)
                begin
                    send_beat(FUNC_READ, 8'($urandom));
                    budget--;
                end
                else if (!drift && pick == 4)
                begin
                    // line noise and broken framing
                    case ($urandom_range(0, 3))
                        0: send_beat(FUNC_RX_BYTE, ACK_BYTE);
                        1: send_beat(FUNC_RX_BYTE, 8'($urandom));
                        2: send_beat(FUNC_RX_BYTE, 8'($urandom) & 8'hF7);
                        default:
                        begin
                            send_beat(FUNC_RX_BYTE, 8'($urandom) | 8'h08);
                            send_beat(FUNC_RX_BYTE, pick_byte());
                        end
                    endcase
                end
                else
                begin
                    status           = 8'($urandom);
                    status[SYNC_BIT] = 1'b1;
                    if (drift || $urandom_range(0, 9) != 0)
                    begin
                        status[XOVF_BIT] = 1'b0;
                        status[YOVF_BIT] = 1'b0;
                    end
                    if (drift)
                    begin
                        // same direction every packet so the sums run past
                        // the signed limits and the wheel sum wraps
                        status[XSIGN_BIT] = xs;
                        status[YSIGN_BIT] = ys;
                        dx = xs ? 8'($urandom_range(0, 40)) : 8'($urandom_range(215, 249));
                        dy = ys ? 8'($urandom_range(0, 40)) : 8'($urandom_range(215, 249));
                        wh = ws ? 8'($urandom_range(128, 200)) : 8'($urandom_range(8, 120));
                    end
                    else
                    begin
                        dx = pick_byte();
                        dy = pick_byte();
                        case ($urandom_range(0, 3))
                            0:       wh = 8'($urandom_range(0, 15));
                            1:       wh = 8'($urandom_range(240, 255));
                            default: wh = pick_byte();
                        endcase
                    end
                    send_frame(status, dx, dy, wh, wide, !drift);
                    budget -= wide ? 4 : 3;
                end
            end
            send_beat(FUNC_READ, 8'($urandom));
        end

        // ---------------- drain and verdict ----------------
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[ps2_mouse_packet_accumulator_core] OK");
        else
            $display("[ps2_mouse_packet_accumulator_core] ERROR");
        $finish;
    end

endmodule
